// ----- rtl/core/htd_pkg.sv -----
// Shared types, constants and helpers for the Huffman tree-walk decoder.
// No dependencies; used by huffman_tree_decoder.
`default_nettype none

package htd_pkg;

    // Table sizing
    localparam int MAX_NODES  = 512;
    localparam int COUNT_BITS = 24;
    localparam int IDX_W      = 9;
    localparam int SYM_W      = 8;
    localparam int PIX_W      = 24;
    localparam int CNT_W      = 25;
    localparam int NODE_DEPTH = (MAX_NODES < (2 ** IDX_W)) ? MAX_NODES : (2 ** IDX_W);
    localparam int ADDR_W     = $clog2(NODE_DEPTH);

    // Pixel index is the count taken modulo 2^COUNT_BITS, then 2^24
    localparam logic [PIX_W-1:0] PIX_MASK = (COUNT_BITS >= PIX_W) ? {PIX_W{1'b1}} :
        PIX_W'((64'd1 << COUNT_BITS) - 64'd1);

    // Request kinds
    typedef enum logic [1:0] {
        KIND_NODE  = 2'd0,
        KIND_BIT   = 2'd1,
        KIND_START = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam logic [0:0] CFG_ROOT  = 1'b0;
    localparam logic [0:0] CFG_TOTAL = 1'b1;

    // Walk controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WALK
    } state_t;

    // Node table entry: [26] leaf, [25:18] symbol, [17:9] left, [8:0] right
    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    // Child followed for a given code bit
    function automatic logic [IDX_W-1:0] child_of(input node_t e, input logic b);
        return b ? e.right : e.left;
    endfunction

    // True when the index maps to a stored entry
    function automatic logic in_range(input logic [IDX_W-1:0] i);
        return (IDX_W+1)'(i) < (IDX_W+1)'(NODE_DEPTH);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/htd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/huffman_tree_decoder.sv -----
// Huffman tree-walk decoder: code tree in a node RAM, one code bit per request.
// Depends on htd_pkg and htd_ram.
// Sequencing: node writes and starts are taken in ST_IDLE; a code bit goes through ST_WALK
// while the current entry is cached, and the first bit after a start or a leaf goes through
// ST_LOAD (walk entry read back first), then ST_WALK unless that entry is a leaf; a bit on
// a cached leaf is emitted from ST_IDLE; output stalls hold the decoder back.
// Reset clears the walk, pixel count and valid flags; node RAM is undefined until written.
`default_nettype none

module huffman_tree_decoder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  kind,
    input  wire logic [htd_pkg::IDX_W-1:0]   node_index,
    input  wire logic                        node_is_leaf,
    input  wire logic [htd_pkg::SYM_W-1:0]   node_symbol,
    input  wire logic [htd_pkg::IDX_W-1:0]   left_child,
    input  wire logic [htd_pkg::IDX_W-1:0]   right_child,
    input  wire logic                        code_bit,

    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [htd_pkg::SYM_W-1:0]   symbol,
    output logic      [htd_pkg::PIX_W-1:0]   pixel_index,
    output logic                             last_pixel,

    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [0:0]                  cfg_index,
    input  wire logic [htd_pkg::CNT_W-1:0]   cfg_data
);

    // Control and walk state
    htd_pkg::state_t                 state_reg, state_next;
    logic [htd_pkg::IDX_W-1:0]       walk_reg, walk_next;
    logic [htd_pkg::CNT_W-1:0]       pixels_reg, pixels_next;
    htd_pkg::node_t                  cur_reg, cur_next;
    logic                            cur_valid_reg, cur_valid_next;
    logic                            bit_reg, bit_next;
    logic [htd_pkg::IDX_W-1:0]       child_reg, child_next;
    logic                            rd_oor_reg, rd_oor_next;
    logic [htd_pkg::IDX_W-1:0]       root_reg;
    logic [htd_pkg::CNT_W-1:0]       total_reg;

    // Output register
    logic                            out_valid_reg, out_valid_next;
    logic [htd_pkg::SYM_W-1:0]       sym_reg, sym_next;
    logic [htd_pkg::PIX_W-1:0]       pix_reg, pix_next;
    logic                            last_reg, last_next;

    // Node RAM ports
    logic                            ram_we;
    logic [htd_pkg::ADDR_W-1:0]      ram_waddr;
    logic [htd_pkg::NODE_W-1:0]      ram_wdata;
    logic                            ram_re;
    logic [htd_pkg::IDX_W-1:0]       rd_idx;
    logic [htd_pkg::NODE_W-1:0]      ram_rdata;

    // Decode helpers
    htd_pkg::node_t                  rd_entry;
    htd_pkg::node_t                  wr_entry;
    htd_pkg::node_t                  emit_entry;
    logic                            emit;
    logic                            out_free;
    logic                            active;
    logic                            cur_leaf;
    logic                            in_fire;
    logic                            bit_fire;
    logic [htd_pkg::CNT_W-1:0]       pixels_inc;

    htd_ram #(
        .WIDTH (htd_pkg::NODE_W),
        .DEPTH (htd_pkg::NODE_DEPTH)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (rd_idx[htd_pkg::ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    // Handshake and shared conditions
    always_comb
    begin
        rd_entry   = rd_oor_reg ? '0 : htd_pkg::node_t'(ram_rdata);
        wr_entry   = '{leaf: node_is_leaf, symbol: node_symbol,
                       left: left_child, right: right_child};
        out_free   = !out_valid_reg || !out_stall;
        active     = pixels_reg < total_reg;
        cur_leaf   = cur_valid_reg && cur_reg.leaf;
        in_stall   = (state_reg != htd_pkg::ST_IDLE) || (cur_leaf && !out_free);
        in_fire    = in_valid && !in_stall;
        bit_fire   = in_fire && (kind == htd_pkg::KIND_BIT) && active;
        pixels_inc = pixels_reg + 1'b1;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            htd_pkg::ST_IDLE:
            begin
                if (bit_fire && !cur_valid_reg)
                begin
                    state_next = htd_pkg::ST_LOAD;
                end
                else if (bit_fire && !cur_reg.leaf)
                begin
                    state_next = htd_pkg::ST_WALK;
                end
            end
            htd_pkg::ST_LOAD:
            begin
                if (!rd_entry.leaf)
                begin
                    state_next = htd_pkg::ST_WALK;
                end
                else if (out_free)
                begin
                    state_next = htd_pkg::ST_IDLE;
                end
            end
            htd_pkg::ST_WALK:
            begin
                if (!rd_entry.leaf || out_free)
                begin
                    state_next = htd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = htd_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM access and emission
    always_comb
    begin
        walk_next      = walk_reg;
        pixels_next    = pixels_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        bit_next       = bit_reg;
        child_next     = child_reg;
        rd_oor_next    = rd_oor_reg;
        ram_we         = 1'b0;
        ram_waddr      = node_index[htd_pkg::ADDR_W-1:0];
        ram_wdata      = wr_entry;
        ram_re         = 1'b0;
        rd_idx         = walk_reg;
        emit           = 1'b0;
        emit_entry     = cur_reg;

        case (state_reg)
            htd_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (kind)
                        htd_pkg::KIND_NODE:
                        begin
                            if (htd_pkg::in_range(node_index))
                            begin
                                ram_we = 1'b1;
                                // keep the cached walk entry coherent
                                if (node_index == walk_reg)
                                begin
                                    cur_next = wr_entry;
                                end
                            end
                        end
                        htd_pkg::KIND_START:
                        begin
                            walk_next      = root_reg;
                            pixels_next    = '0;
                            cur_valid_next = 1'b0;
                        end
                        htd_pkg::KIND_BIT:
                        begin
                            if (active)
                            begin
                                if (!cur_valid_reg)
                                begin
                                    // fetch the walk entry first
                                    bit_next    = code_bit;
                                    ram_re      = 1'b1;
                                    rd_idx      = walk_reg;
                                    rd_oor_next = !htd_pkg::in_range(walk_reg);
                                end
                                else if (cur_reg.leaf)
                                begin
                                    emit       = 1'b1;
                                    emit_entry = cur_reg;
                                end
                                else
                                begin
                                    rd_idx      = htd_pkg::child_of(cur_reg, code_bit);
                                    ram_re      = 1'b1;
                                    child_next  = rd_idx;
                                    rd_oor_next = !htd_pkg::in_range(rd_idx);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            htd_pkg::ST_LOAD:
            begin
                cur_next       = rd_entry;
                cur_valid_next = 1'b1;
                if (rd_entry.leaf)
                begin
                    emit       = out_free;
                    emit_entry = rd_entry;
                end
                else
                begin
                    rd_idx      = htd_pkg::child_of(rd_entry, bit_reg);
                    ram_re      = 1'b1;
                    child_next  = rd_idx;
                    rd_oor_next = !htd_pkg::in_range(rd_idx);
                end
            end
            htd_pkg::ST_WALK:
            begin
                if (rd_entry.leaf)
                begin
                    emit       = out_free;
                    emit_entry = rd_entry;
                end
                else
                begin
                    cur_next       = rd_entry;
                    cur_valid_next = 1'b1;
                    walk_next      = child_reg;
                end
            end
            default:
            begin
            end
        endcase

        // leaf reached: count the pixel and return to the root
        if (emit)
        begin
            pixels_next    = pixels_inc;
            walk_next      = root_reg;
            cur_valid_next = 1'b0;
        end
    end

    // Output register next values
    always_comb
    begin
        out_valid_next = out_free ? emit : 1'b1;
        sym_next       = sym_reg;
        pix_next       = pix_reg;
        last_next      = last_reg;
        if (emit)
        begin
            sym_next  = emit_entry.symbol;
            pix_next  = pixels_reg[htd_pkg::PIX_W-1:0] & htd_pkg::PIX_MASK;
            last_next = (pixels_inc == total_reg);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= htd_pkg::ST_IDLE;
            walk_reg      <= '0;
            pixels_reg    <= '0;
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            pixels_reg    <= pixels_next;
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        bit_reg    <= bit_next;
        child_reg  <= child_next;
        rd_oor_reg <= rd_oor_next;
        sym_reg    <= sym_next;
        pix_reg    <= pix_next;
        last_reg   <= last_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg  <= '0;
            total_reg <= htd_pkg::CNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                htd_pkg::CFG_ROOT:  root_reg  <= cfg_data[htd_pkg::IDX_W-1:0];
                htd_pkg::CFG_TOTAL: total_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign symbol      = sym_reg;
    assign pixel_index = pix_reg;
    assign last_pixel  = last_reg;

endmodule

`default_nettype wire
